### rtl/ftwm_pkg.sv
// ftwm_pkg: shared types and constants of the frame-time window monitor
// no dependencies; compiled before the interfaces and all modules
`timescale 1ns / 1ps

package ftwm_pkg;

    localparam int MODE_W     = 2;
    localparam int NUM_W      = 32;
    localparam int TALLY_W    = 16;
    localparam int WLEN_W     = 14;
    localparam int THR_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MIN_WINDOW       = 16;
    localparam int RESET_WINDOW_LEN = 1024;

    localparam logic [TALLY_W-1:0] TALLY_MAX          = '1;
    localparam logic [THR_W-1:0]   MIN_THRESHOLD_US   = THR_W'(1000);
    localparam logic [THR_W-1:0]   RESET_THRESHOLD_US = THR_W'(50000);

    typedef enum logic [MODE_W-1:0] {
        MODE_RECORD   = 2'd0,
        MODE_COMPLETE = 2'd1,
        MODE_CLEAR    = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN = 2'd0,
        REG_THRESHOLD  = 2'd1
    } t_reg_index;

endpackage

### rtl/ftwm_frame_if.sv
// ftwm_frame_if: input channel of the monitor, one frame item per transaction
// depends on ftwm_pkg
`timescale 1ns / 1ps

interface ftwm_frame_if #(
    parameter int TIME_BITS = 20
);
    import ftwm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] frame_us;
    logic [NUM_W-1:0]     frame_number;

    modport source (output valid, mode, frame_us, frame_number, input ready);
    modport sink   (input valid, mode, frame_us, frame_number, output ready);
endinterface

### rtl/ftwm_stats_if.sv
// ftwm_stats_if: result channel of the monitor, window statistics per transaction
// depends on ftwm_pkg
`timescale 1ns / 1ps

interface ftwm_stats_if #(
    parameter int TIME_BITS = 20,
    parameter int SLOT_W    = 13,
    parameter int CNT_W     = 14
);
    import ftwm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SLOT_W-1:0]    slot_index;
    logic                 frame_is_hitch;
    logic [CNT_W-1:0]     window_count;
    logic                 worst_valid;
    logic [TIME_BITS-1:0] worst_us;
    logic [NUM_W-1:0]     worst_frame_number;
    logic [TIME_BITS-1:0] average_us;
    logic [CNT_W-1:0]     hitch_count;
    logic [TALLY_W-1:0]   newest_completions;

    modport source (
        output valid, slot_index, frame_is_hitch, window_count, worst_valid, worst_us,
               worst_frame_number, average_us, hitch_count, newest_completions,
        input  ready
    );
    modport sink (
        input  valid, slot_index, frame_is_hitch, window_count, worst_valid, worst_us,
               worst_frame_number, average_us, hitch_count, newest_completions,
        output ready
    );
endinterface

### rtl/ftwm_cfg_if.sv
// ftwm_cfg_if: register write channel, index and data per transaction
// depends on ftwm_pkg
`timescale 1ns / 1ps

interface ftwm_cfg_if;
    import ftwm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/frame_time_window_monitor_top.sv
// frame_time_window_monitor_top: frame-time monitor over a ring of recent frames
// depends on ftwm_pkg, ftwm_frame_if, ftwm_stats_if, ftwm_cfg_if, ftwm_ram, ftwm_div
//
// usage:
//   i_frame carries one item per transaction: mode 0 records a frame time and
//   number, mode 1 counts a completion on the newest frame, mode 2 clears the
//   window. o_stats returns one transaction per item with the window count,
//   the worst time and its frame number, the truncated mean, the hitch count
//   and the completion count of the newest frame. i_cfg writes window_len
//   (index 0) or hitch_threshold_us (index 1); either write empties the window.
//   frame times, numbers and hitch flags live in one ram with a registered read.
// timing:
//   a record item reads the slot it overwrites, writes it, then walks all n
//   held frames one ram read per cycle; its result then waits for the serial
//   mean divider to finish. other modes reuse the stats of the last walk and
//   go straight to the output register. one item is in work at a time.
// reset and stall:
//   reset empties the window and loads window_len 1024 and threshold 50000 us;
//   no clearing pass is needed. the result waits in an output register while
//   the receiver stalls, and a following item is accepted and worked on
//   meanwhile; it holds in its last state until the register frees up.
`timescale 1ns / 1ps

module frame_time_window_monitor_top #(
    parameter int MAX_WINDOW = 8192,
    parameter int TIME_BITS  = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ftwm_frame_if.sink   i_frame,
    ftwm_stats_if.source o_stats,
    ftwm_cfg_if.sink     i_cfg
);
    import ftwm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = TIME_BITS + SLOT_W;
    localparam int RAM_W  = TIME_BITS + NUM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_OLD,
        S_WRITE,
        S_SCAN,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    function automatic logic [CNT_W-1:0] clamp_len(input logic [WLEN_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w < 32'(MIN_WINDOW)) w = 32'(MIN_WINDOW);
        if (w > 32'(MAX_WINDOW)) w = 32'(MAX_WINDOW);
        return CNT_W'(w);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CNT_W-1:0]  len);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(s) + 1'b1;
        return (inc == len) ? '0 : SLOT_W'(inc);
    endfunction

    // control state
    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]    r_head, n_head;
    logic [SLOT_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]     r_held, n_held;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_hitch_total, n_hitch_total;
    logic [TALLY_W-1:0]   r_tally, n_tally;
    logic [CNT_W-1:0]     r_ring_len, n_ring_len;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic                 r_div_start, n_div_start;
    logic [CNT_W-1:0]     r_left, n_left;
    logic                 r_pend, n_pend;

    // working payload
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [NUM_W-1:0]     r_num, n_num;
    logic                 r_hitch, n_hitch;
    logic [SLOT_W-1:0]    r_slot_out, n_slot_out;
    logic                 r_hitch_out, n_hitch_out;
    logic [SLOT_W-1:0]    r_pos, n_pos;
    logic                 r_first, n_first;
    logic [TIME_BITS-1:0] r_worst_us, n_worst_us;
    logic [NUM_W-1:0]     r_worst_num, n_worst_num;
    logic [TIME_BITS-1:0] r_avg, n_avg;

    // output register
    logic [SLOT_W-1:0]    r_o_slot, n_o_slot;
    logic                 r_o_hitch, n_o_hitch;
    logic [CNT_W-1:0]     r_o_count, n_o_count;
    logic                 r_o_worst_valid, n_o_worst_valid;
    logic [TIME_BITS-1:0] r_o_worst_us, n_o_worst_us;
    logic [NUM_W-1:0]     r_o_worst_num, n_o_worst_num;
    logic [TIME_BITS-1:0] r_o_avg, n_o_avg;
    logic [CNT_W-1:0]     r_o_hitch_count, n_o_hitch_count;
    logic [TALLY_W-1:0]   r_o_tally, n_o_tally;

    logic                 frame_accept;
    logic                 cfg_accept;
    logic                 out_free;
    logic                 full;
    logic                 held_any;

    logic                 ram_we;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [RAM_W-1:0]     ram_rdata;
    logic [TIME_BITS-1:0] rd_time;
    logic [NUM_W-1:0]     rd_num;
    logic                 rd_hitch;

    logic                 div_busy;
    logic [TIME_BITS-1:0] div_quotient;

    assign i_frame.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign frame_accept  = i_frame.valid && (r_state == S_IDLE);
    assign cfg_accept    = i_cfg.valid;
    assign out_free      = !r_out_valid || o_stats.ready;
    assign full          = (r_held >= r_ring_len);
    assign held_any      = (r_held != '0);

    assign ram_wdata = {r_hitch, r_num, r_time};
    assign rd_time   = ram_rdata[TIME_BITS-1:0];
    assign rd_num    = ram_rdata[TIME_BITS +: NUM_W];
    assign rd_hitch  = ram_rdata[RAM_W-1];

    ftwm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ftwm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        n_head          = r_head;
        n_tail          = r_tail;
        n_held          = r_held;
        n_sum           = r_sum;
        n_hitch_total   = r_hitch_total;
        n_tally         = r_tally;
        n_ring_len      = r_ring_len;
        n_thr           = r_thr;
        n_div_start     = 1'b0;
        n_left          = r_left;
        n_pend          = r_pend;
        n_time          = r_time;
        n_num           = r_num;
        n_hitch         = r_hitch;
        n_slot_out      = r_slot_out;
        n_hitch_out     = r_hitch_out;
        n_pos           = r_pos;
        n_first         = r_first;
        n_worst_us      = r_worst_us;
        n_worst_num     = r_worst_num;
        n_avg           = r_avg;
        n_o_slot        = r_o_slot;
        n_o_hitch       = r_o_hitch;
        n_o_count       = r_o_count;
        n_o_worst_valid = r_o_worst_valid;
        n_o_worst_us    = r_o_worst_us;
        n_o_worst_num   = r_o_worst_num;
        n_o_avg         = r_o_avg;
        n_o_hitch_count = r_o_hitch_count;
        n_o_tally       = r_o_tally;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = r_head;

        if (r_out_valid && o_stats.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (frame_accept) begin
                    n_time      = i_frame.frame_us;
                    n_num       = i_frame.frame_number;
                    n_hitch     = (32'(i_frame.frame_us) >= 32'(r_thr));
                    n_slot_out  = '0;
                    n_hitch_out = 1'b0;
                    n_state     = S_OUT;
                    case (i_frame.mode)
                        MODE_RECORD: begin
                            // add the new time now, the overwritten one leaves later
                            n_sum = r_sum + SUM_W'(i_frame.frame_us);
                            n_hitch_total = r_hitch_total
                                + CNT_W'(32'(i_frame.frame_us) >= 32'(r_thr));
                            n_state = S_READ_OLD;
                        end
                        MODE_COMPLETE: begin
                            if (held_any && (r_tally != TALLY_MAX)) begin
                                n_tally = r_tally + 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            n_head        = '0;
                            n_tail        = '0;
                            n_held        = '0;
                            n_sum         = '0;
                            n_hitch_total = '0;
                            n_tally       = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ_OLD: begin
                ram_re    = 1'b1;
                ram_raddr = r_head;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                ram_we      = 1'b1;
                n_head      = next_slot(r_head, r_ring_len);
                n_slot_out  = r_head;
                n_hitch_out = r_hitch;
                n_tally     = '0;
                n_div_start = 1'b1;
                n_pend      = 1'b0;
                n_first     = 1'b1;
                if (full) begin
                    n_sum         = r_sum - SUM_W'(rd_time);
                    n_hitch_total = r_hitch_total - CNT_W'(rd_hitch);
                    n_tail        = next_slot(r_tail, r_ring_len);
                    n_pos         = next_slot(r_tail, r_ring_len);
                    n_left        = r_held;
                end else begin
                    n_held = r_held + 1'b1;
                    n_pos  = r_tail;
                    n_left = r_held + 1'b1;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // walk oldest to newest; the write landed before the first read
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_pos;
                    n_pos     = next_slot(r_pos, r_ring_len);
                    n_left    = r_left - 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_first = 1'b0;
                    // strict compare keeps the earliest frame on ties
                    if (r_first || (rd_time > r_worst_us)) begin
                        n_worst_us  = rd_time;
                        n_worst_num = rd_num;
                    end
                end
                if ((r_left == '0) && !r_pend) begin
                    n_state = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (!r_div_start && !div_busy) begin
                    n_avg   = div_quotient;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_o_slot        = r_slot_out;
                    n_o_hitch       = r_hitch_out;
                    n_o_count       = r_held;
                    n_o_worst_valid = held_any;
                    n_o_worst_us    = held_any ? r_worst_us : '0;
                    n_o_worst_num   = held_any ? r_worst_num : '0;
                    n_o_avg         = held_any ? r_avg : '0;
                    n_o_hitch_count = r_hitch_total;
                    n_o_tally       = r_tally;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_accept) begin
            case (i_cfg.index)
                REG_WINDOW_LEN: begin
                    n_ring_len    = clamp_len(i_cfg.data[WLEN_W-1:0]);
                    n_head        = '0;
                    n_tail        = '0;
                    n_held        = '0;
                    n_sum         = '0;
                    n_hitch_total = '0;
                    n_tally       = '0;
                end
                REG_THRESHOLD: begin
                    n_thr = (i_cfg.data[THR_W-1:0] < MIN_THRESHOLD_US) ?
                            MIN_THRESHOLD_US : i_cfg.data[THR_W-1:0];
                    n_head        = '0;
                    n_tail        = '0;
                    n_held        = '0;
                    n_sum         = '0;
                    n_hitch_total = '0;
                    n_tally       = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_held        <= '0;
            r_sum         <= '0;
            r_hitch_total <= '0;
            r_tally       <= '0;
            r_ring_len    <= clamp_len(WLEN_W'(RESET_WINDOW_LEN));
            r_thr         <= RESET_THRESHOLD_US;
            r_div_start   <= 1'b0;
            r_left        <= '0;
            r_pend        <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_head          <= n_head;
            r_tail          <= n_tail;
            r_held          <= n_held;
            r_sum           <= n_sum;
            r_hitch_total   <= n_hitch_total;
            r_tally         <= n_tally;
            r_ring_len      <= n_ring_len;
            r_thr           <= n_thr;
            r_div_start     <= n_div_start;
            r_left          <= n_left;
            r_pend          <= n_pend;
            r_time          <= n_time;
            r_num           <= n_num;
            r_hitch         <= n_hitch;
            r_slot_out      <= n_slot_out;
            r_hitch_out     <= n_hitch_out;
            r_pos           <= n_pos;
            r_first         <= n_first;
            r_worst_us      <= n_worst_us;
            r_worst_num     <= n_worst_num;
            r_avg           <= n_avg;
            r_o_slot        <= n_o_slot;
            r_o_hitch       <= n_o_hitch;
            r_o_count       <= n_o_count;
            r_o_worst_valid <= n_o_worst_valid;
            r_o_worst_us    <= n_o_worst_us;
            r_o_worst_num   <= n_o_worst_num;
            r_o_avg         <= n_o_avg;
            r_o_hitch_count <= n_o_hitch_count;
            r_o_tally       <= n_o_tally;
        end
    end

    assign o_stats.valid              = r_out_valid;
    assign o_stats.slot_index         = r_o_slot;
    assign o_stats.frame_is_hitch     = r_o_hitch;
    assign o_stats.window_count       = r_o_count;
    assign o_stats.worst_valid        = r_o_worst_valid;
    assign o_stats.worst_us           = r_o_worst_us;
    assign o_stats.worst_frame_number = r_o_worst_num;
    assign o_stats.average_us         = r_o_avg;
    assign o_stats.hitch_count        = r_o_hitch_count;
    assign o_stats.newest_completions = r_o_tally;

    a_held_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_ring_len)
        else $error("window holds more frames than ring slots");

    a_pointers_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_head) < r_ring_len) && (CNT_W'(r_tail) < r_ring_len))
        else $error("ring pointer beyond ring length");

    a_hitch_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_hitch_total <= r_held))
        else $error("hitch count exceeds frames held");

    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |=> div_busy)
        else $error("mean divider did not start");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=>
            (r_out_valid && (o_stats.worst_valid == (o_stats.window_count != '0))))
        else $error("result loaded with inconsistent worst flag");

endmodule

### rtl/ftwm_ram.sv
// ftwm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ftwm_ram #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

### rtl/ftwm_div.sv
// ftwm_div: restoring divider for the window mean, one quotient bit per cycle
// no dependencies; busy after a start until all DIVIDEND_W quotient bits are shifted in
`timescale 1ns / 1ps

module ftwm_div #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 14,
    parameter int QUOT_W     = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [QUOT_W-1:0]     o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [STEP_W-1:0]     r_steps;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
        // remainder stays below the divisor, so the top bit drops
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_start) begin
            r_steps   <= STEP_W'(DIVIDEND_W);
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_steps != '0) begin
            r_steps <= r_steps - 1'b1;
            r_rem   <= n_rem;
            r_quo   <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_busy     = (r_steps != '0);
    assign o_quotient = r_quo[QUOT_W-1:0];

endmodule

### dv/frame_time_window_monitor_top_test.sv
// frame_time_window_monitor_top_test: self-checking bench for the frame-time window monitor
// depends on ftwm_pkg, ftwm_frame_if, ftwm_stats_if, ftwm_cfg_if and the rtl under test
// directed items and register extremes, then random frame traffic under random flow control
`timescale 1ns / 1ps

module frame_time_window_monitor_top_test;
    import ftwm_pkg::*;

    localparam int MAX_WINDOW = 8192;
    localparam int TIME_BITS  = 20;
    localparam int SLOT_W     = 13;
    localparam int CNT_W      = 14;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot_index;
        logic                 frame_is_hitch;
        logic [CNT_W-1:0]     window_count;
        logic                 worst_valid;
        logic [TIME_BITS-1:0] worst_us;
        logic [NUM_W-1:0]     worst_frame_number;
        logic [TIME_BITS-1:0] average_us;
        logic [CNT_W-1:0]     hitch_count;
        logic [TALLY_W-1:0]   newest_completions;
    } t_window_stats;

    logic i_clk;
    logic i_rst_n;

    ftwm_frame_if #(.TIME_BITS(TIME_BITS)) frame_ch ();
    ftwm_stats_if #(.TIME_BITS(TIME_BITS), .SLOT_W(SLOT_W), .CNT_W(CNT_W)) stats_ch ();
    ftwm_cfg_if cfg_ch ();

    frame_time_window_monitor_top #(
        .MAX_WINDOW(MAX_WINDOW),
        .TIME_BITS (TIME_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_frame(frame_ch),
        .o_stats(stats_ch),
        .i_cfg  (cfg_ch)
    );

    // shadow copy of the window
    logic [TIME_BITS-1:0] time_mem [MAX_WINDOW];
    logic [NUM_W-1:0]     num_mem  [MAX_WINDOW];
    bit                   hitch_mem[MAX_WINDOW];
    int                   head_pos;
    int                   held;
    longint unsigned      sum_us;
    int                   hitch_total;
    int                   tally;
    logic [WLEN_W-1:0]    wlen_reg = WLEN_W'(RESET_WINDOW_LEN);
    logic [THR_W-1:0]     thr_reg  = RESET_THRESHOLD_US;

    t_window_stats        pending_stats[$];
    logic [TIME_BITS-1:0] last_time;
    bit                   steady_flow;
    int                   burst_left;
    int                   items_sent;
    int                   stats_seen;
    int                   reg_writes;
    int                   fault_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("frame_time_window_monitor_top_test: errors");
        $finish;
    end

    function automatic void empty_window();
        head_pos    = 0;
        held        = 0;
        sum_us      = 0;
        hitch_total = 0;
        tally       = 0;
    endfunction

    function automatic int ring_length();
        int len;
        len = int'(wlen_reg);
        if (len < MIN_WINDOW) len = MIN_WINDOW;
        if (len > MAX_WINDOW) len = MAX_WINDOW;
        return len;
    endfunction

    function automatic logic [THR_W-1:0] live_threshold();
        return (thr_reg < MIN_THRESHOLD_US) ? MIN_THRESHOLD_US : thr_reg;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == REG_WINDOW_LEN) begin
            wlen_reg = data[WLEN_W-1:0];
            empty_window();
        end else if (idx == REG_THRESHOLD) begin
            thr_reg = data[THR_W-1:0];
            empty_window();
        end
    endfunction

    // updates the shadow window with one item and returns the stats it yields
    function automatic t_window_stats advance_window(logic [MODE_W-1:0] mode,
                                                     logic [TIME_BITS-1:0] us,
                                                     logic [NUM_W-1:0] num);
        t_window_stats r;
        int len;
        int idx;
        int pos;
        logic [TIME_BITS-1:0] worst_t;
        logic [NUM_W-1:0] worst_n;
        r   = '0;
        len = ring_length();
        if (mode == MODE_RECORD) begin
            idx = head_pos % len;
            if (held >= len) begin
                sum_us      = sum_us - 64'(time_mem[idx]);
                hitch_total = hitch_total - int'(hitch_mem[idx]);
            end else begin
                held++;
            end
            time_mem[idx]  = us;
            num_mem[idx]   = num;
            hitch_mem[idx] = (us >= live_threshold());
            sum_us         = sum_us + 64'(us);
            hitch_total    = hitch_total + int'(hitch_mem[idx]);
            tally          = 0;
            head_pos       = (idx + 1) % len;
            r.slot_index     = SLOT_W'(idx);
            r.frame_is_hitch = hitch_mem[idx];
        end else if (mode == MODE_COMPLETE) begin
            if (held > 0 && tally < int'(TALLY_MAX)) tally++;
        end else if (mode == MODE_CLEAR) begin
            empty_window();
        end
        r.window_count       = CNT_W'(held);
        r.hitch_count        = CNT_W'(hitch_total);
        r.newest_completions = TALLY_W'(tally);
        if (held > 0) begin
            // oldest frame first so that ties keep the earliest one
            pos     = (head_pos % len + len - held) % len;
            worst_t = time_mem[pos];
            worst_n = num_mem[pos];
            for (int k = 1; k < held; k++) begin
                pos = (pos + 1) % len;
                if (time_mem[pos] > worst_t) begin
                    worst_t = time_mem[pos];
                    worst_n = num_mem[pos];
                end
            end
            r.worst_valid        = 1'b1;
            r.worst_us           = worst_t;
            r.worst_frame_number = worst_n;
            r.average_us         = TIME_BITS'(sum_us / longint'(held));
        end
        return r;
    endfunction

    task automatic send_frame(logic [MODE_W-1:0] mode, logic [TIME_BITS-1:0] us,
                              logic [NUM_W-1:0] num);
        int gap_len;
        gap_len = 0;
        if (!steady_flow && burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        @(negedge i_clk);
        if (gap_len > 0) begin
            frame_ch.valid = 1'b0;
            repeat (gap_len) @(negedge i_clk);
        end
        frame_ch.mode         = mode;
        frame_ch.frame_us     = us;
        frame_ch.frame_number = num;
        frame_ch.valid        = 1'b1;
        @(posedge i_clk);
        while (frame_ch.ready !== 1'b1) @(posedge i_clk);
        pending_stats.push_back(advance_window(mode, us, num));
        items_sent++;
        burst_left--;
    endtask

    // only while the monitor is idle: every stats transaction back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        frame_ch.valid = 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return MODE_RECORD;
        if (r == 17) return MODE_CLEAR;
        if (r == 18) return MODE_UNUSED;
        return MODE_COMPLETE;
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_frame_time();
        logic [TIME_BITS-1:0] t;
        case ($urandom_range(0, 9))
            4:       t = live_threshold() - 1'b1 + TIME_BITS'($urandom_range(0, 2));
            5:       t = '0;
            6:       t = '1;
            7:       t = last_time;  // repeats make ties in the worst search
            8, 9:    t = TIME_BITS'($urandom_range(0, 2000));
            default: t = TIME_BITS'($urandom());
        endcase
        last_time = t;
        return t;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (fault_count < 10)
                $display("stats #%0d %s: expected %0h, got %0h", stats_seen, fname, want, got);
            fault_count++;
        end
    endfunction

    // receiver: ready style is redrawn at random, long stalls included
    initial begin : stats_sink
        int rx_style;
        int rx_cycle;
        int stall_left;
        rx_style       = 0;
        rx_cycle       = 0;
        stall_left     = 0;
        stats_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 50 == 0) rx_style = $urandom_range(0, 3);
            if (steady_flow || rx_style == 0) begin
                stats_ch.ready = 1'b1;
            end else if (rx_style == 1) begin
                stats_ch.ready = $urandom_range(0, 1);
            end else if (rx_style == 2) begin
                stats_ch.ready = ($urandom_range(0, 2) == 0);
            end else if (stall_left > 0) begin
                stats_ch.ready = 1'b0;
                stall_left--;
            end else begin
                stats_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 20);
            end
        end
    end

    always @(posedge i_clk) begin : stats_check
        t_window_stats want;
        if (i_rst_n && stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1) begin
            if (pending_stats.size() == 0) begin
                if (fault_count < 10) $display("stats transaction with nothing pending");
                fault_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("slot_index", 32'(want.slot_index), 32'(stats_ch.slot_index));
                check_field("frame_is_hitch", 32'(want.frame_is_hitch),
                            32'(stats_ch.frame_is_hitch));
                check_field("window_count", 32'(want.window_count), 32'(stats_ch.window_count));
                check_field("worst_valid", 32'(want.worst_valid), 32'(stats_ch.worst_valid));
                check_field("worst_us", 32'(want.worst_us), 32'(stats_ch.worst_us));
                check_field("worst_frame_number", want.worst_frame_number,
                            stats_ch.worst_frame_number);
                check_field("average_us", 32'(want.average_us), 32'(stats_ch.average_us));
                check_field("hitch_count", 32'(want.hitch_count), 32'(stats_ch.hitch_count));
                check_field("newest_completions", 32'(want.newest_completions),
                            32'(stats_ch.newest_completions));
            end
            stats_seen++;
        end
    end

    task automatic test_empty_window();
        send_frame(MODE_COMPLETE, '1, '1);
        send_frame(MODE_UNUSED, '0, '0);
        send_frame(MODE_CLEAR, '1, '0);
    endtask

    // reset settings: length 1024, threshold 50000 us
    task automatic test_reset_settings();
        send_frame(MODE_RECORD, TIME_BITS'(49999), 32'h0000_0000);
        send_frame(MODE_RECORD, TIME_BITS'(50000), 32'hFFFF_FFFF);
        send_frame(MODE_RECORD, '0, 32'h5A5A_5A5A);
        send_frame(MODE_RECORD, '1, 32'h1234_5678);
        send_frame(MODE_RECORD, '1, 32'hA5A5_A5A5);
        send_frame(MODE_COMPLETE, '0, '0);
        send_frame(MODE_COMPLETE, '1, '1);
        send_frame(MODE_UNUSED, '1, '1);
        send_frame(MODE_RECORD, TIME_BITS'(70000), 32'h0000_0042);
        send_frame(MODE_CLEAR, '0, '0);
        send_frame(MODE_COMPLETE, '0, '0);
    endtask

    task automatic test_register_extremes();
        // length and threshold below range get clamped; upper data bits are don't care
        write_reg(REG_WINDOW_LEN, 32'hFFFF_C000);
        write_reg(REG_THRESHOLD, 32'hFFF0_0000);
        send_frame(MODE_RECORD, TIME_BITS'(999), 32'h0000_0001);
        send_frame(MODE_RECORD, TIME_BITS'(1000), 32'h0000_0002);
        // spare indexes leave the window alone
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h0000_0010);
        send_frame(MODE_COMPLETE, '0, '0);
        write_reg(REG_WINDOW_LEN, 32'h0000_3FFF);
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        send_frame(MODE_RECORD, '1, 32'hDEAD_BEEF);
        send_frame(MODE_RECORD, TIME_BITS'(20'hFFFFE), 32'h0BAD_F00D);
        write_reg(REG_WINDOW_LEN, 32'(MAX_WINDOW));
        write_reg(REG_THRESHOLD, 32'(MIN_THRESHOLD_US));
        send_frame(MODE_RECORD, TIME_BITS'(1000), 32'h7777_7777);
        write_reg(REG_WINDOW_LEN, 32'(MIN_WINDOW));
        write_reg(REG_THRESHOLD, 32'h000F_FFFF);
        send_frame(MODE_RECORD, '1, 32'h8000_0000);
    endtask

    // completions count on the newest frame, a new frame restarts the tally
    task automatic test_tally_restart();
        write_reg(REG_WINDOW_LEN, 32'(MIN_WINDOW));
        send_frame(MODE_RECORD, TIME_BITS'(16667), $urandom());
        repeat (4) send_frame(MODE_COMPLETE, TIME_BITS'($urandom()), $urandom());
        send_frame(MODE_RECORD, TIME_BITS'(33333), $urandom());
        send_frame(MODE_COMPLETE, '0, '0);
    endtask

    task automatic test_random_traffic();
        int n_items;
        logic [WLEN_W-1:0] len;
        logic [THR_W-1:0] thr;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 4))
                0:       len = WLEN_W'(MIN_WINDOW);
                1:       len = WLEN_W'(17);
                2:       len = WLEN_W'($urandom_range(0, 15));
                3:       len = WLEN_W'($urandom_range(18, 48));
                default: len = WLEN_W'(23);
            endcase
            case ($urandom_range(0, 2))
                0:       thr = THR_W'($urandom_range(0, 999));
                1:       thr = THR_W'($urandom());
                default: thr = THR_W'($urandom_range(1000, 200000));
            endcase
            n_items = $urandom_range(6, 10);
            if (phase == 0) begin
                // long run on the shortest ring so it wraps
                len     = WLEN_W'(MIN_WINDOW);
                n_items = 34;
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_WINDOW_LEN, ($urandom() & 32'hFFFF_C000) | 32'(len));
                write_reg(REG_THRESHOLD, ($urandom() & 32'hFFF0_0000) | 32'(thr));
            end else begin
                write_reg(REG_THRESHOLD, ($urandom() & 32'hFFF0_0000) | 32'(thr));
                write_reg(REG_WINDOW_LEN, ($urandom() & 32'hFFFF_C000) | 32'(len));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
            repeat (n_items) send_frame(pick_mode(), pick_frame_time(), $urandom());
        end
    endtask

    initial begin
        frame_ch.valid        = 1'b0;
        frame_ch.mode         = '0;
        frame_ch.frame_us     = '0;
        frame_ch.frame_number = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        i_rst_n               = 1'b0;
        steady_flow           = 1'b0;
        burst_left            = 0;
        items_sent            = 0;
        stats_seen            = 0;
        reg_writes            = 0;
        fault_count           = 0;
        last_time             = '0;
        empty_window();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        test_empty_window();
        test_reset_settings();
        test_register_extremes();
        test_tally_restart();
        test_random_traffic();

        @(negedge i_clk);
        frame_ch.valid = 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d frame items, %0d stats transactions, %0d register writes",
                 items_sent, stats_seen, reg_writes);
        $display("ring lengths clamped at both ends, wrap on short rings, tally restart");
        if (fault_count == 0) begin
            $display("frame_time_window_monitor_top_test: clean");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("frame_time_window_monitor_top_test: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ftwm_pkg.sv
rtl/ftwm_frame_if.sv
rtl/ftwm_stats_if.sv
rtl/ftwm_cfg_if.sv
rtl/ftwm_ram.sv
rtl/ftwm_div.sv
rtl/frame_time_window_monitor_top.sv
dv/frame_time_window_monitor_top_test.sv
